/* hdl/pvaf_pkg.sv */
// ----------------------------------------------------------------------------
// pvaf_pkg
// shared constants, types and the arctangent table of the bin converter
// ----------------------------------------------------------------------------
package pvaf_pkg;

    localparam int FFT_SIZE     = 1024;
    localparam int PHASE_BITS   = 16;
    localparam int NUM_BINS     = FFT_SIZE / 2 + 1;
    localparam int BIN_W        = 10;
    localparam int CORDIC_STEPS = 32;
    localparam int CW           = 36;
    localparam int Q_DEPTH      = 64;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int OUT_LIMIT    = Q_DEPTH;
    localparam int OUT_W        = $clog2(OUT_LIMIT + 2);
    localparam int CLR_W        = $clog2(NUM_BINS);

    typedef enum logic [1:0] {
        CFG_HOP_RATE    = 2'd0,
        CFG_BIN_SPACING = 2'd1,
        CFG_MIN_MAG     = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        we;
        t_cfg_idx    idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic             vld;
        logic [BIN_W-1:0] bin;
        logic [31:0]      mag;
        logic [31:0]      z;
        logic             zero;
    } t_front_out;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [31:0]        mag;
        logic signed [31:0] freq;
    } t_result;

    function automatic logic [31:0] atan_turns(input int k);
        logic [31:0] a;
        case (k)
            0:  a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
            3:  a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
            9:  a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
            12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9;
            15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
            18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
            21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
            24: a = 32'h00000029; 25: a = 32'h00000014; 26: a = 32'h0000000A;
            27: a = 32'h00000005; 28: a = 32'h00000003; 29: a = 32'h00000001;
            30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

/* hdl/pvaf_front.sv */
// ----------------------------------------------------------------------------
// pvaf_front
// input capture, squaring, pipelined square root and vectoring cordic
// ----------------------------------------------------------------------------
module pvaf_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [9:0]             i_bin_index,
    input  logic signed [31:0]     i_real_part,
    input  logic signed [31:0]     i_imag_part,
    output pvaf_pkg::t_front_out   o_front
);
    import pvaf_pkg::*;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic [63:0]        v;
        logic [34:0]        rem;
        logic [31:0]        root;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]        z;
        logic               zero;
    } t_fstage;

    logic               r_in_vld;
    logic [BIN_W-1:0]   r_in_bin;
    logic signed [31:0] r_in_re;
    logic signed [31:0] r_in_im;

    logic                 r_p_vld;
    logic [BIN_W-1:0]     r_p_bin;
    logic [63:0]          r_p_re2;
    logic [63:0]          r_p_im2;
    logic signed [CW-1:0] r_p_x;
    logic signed [CW-1:0] r_p_y;
    logic [31:0]          r_p_z;
    logic                 r_p_zero;

    logic    r_vld [0:CORDIC_STEPS];
    t_fstage r_st  [0:CORDIC_STEPS];
    t_fstage n_st  [1:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_p_vld  <= 1'b0;
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_in_vld <= i_accept;
            r_p_vld  <= r_in_vld;
            r_vld[0] <= r_p_vld;
            for (int k = 1; k <= CORDIC_STEPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // input capture, squaring and half-turn pre-rotation
    always_ff @(posedge i_clk) begin
        r_in_bin <= i_bin_index;
        r_in_re  <= i_real_part;
        r_in_im  <= i_imag_part;
        r_p_bin  <= r_in_bin;
        r_p_re2  <= 64'(r_in_re * r_in_re);
        r_p_im2  <= 64'(r_in_im * r_in_im);
        r_p_zero <= (r_in_re == 32'sd0) && (r_in_im == 32'sd0);
        if (r_in_re < 32'sd0) begin
            r_p_x <= -CW'(r_in_re);
            r_p_y <= -CW'(r_in_im);
            r_p_z <= 32'h80000000;
        end else begin
            r_p_x <= CW'(r_in_re);
            r_p_y <= CW'(r_in_im);
            r_p_z <= 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0].bin  <= r_p_bin;
        r_st[0].v    <= r_p_re2 + r_p_im2;
        r_st[0].rem  <= 35'd0;
        r_st[0].root <= 32'd0;
        r_st[0].x    <= r_p_x;
        r_st[0].y    <= r_p_y;
        r_st[0].z    <= r_p_z;
        r_st[0].zero <= r_p_zero;
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            r_st[k] <= n_st[k];
        end
    end

    // one root digit and one cordic micro-rotation per stage
    always_comb begin
        logic [34:0] rr;
        logic [34:0] t;
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            n_st[k]     = r_st[k-1];
            rr          = {r_st[k-1].rem[32:0], r_st[k-1].v[63:62]};
            t           = {1'b0, r_st[k-1].root, 2'b01};
            n_st[k].v   = {r_st[k-1].v[61:0], 2'b00};
            if (rr >= t) begin
                n_st[k].rem  = rr - t;
                n_st[k].root = {r_st[k-1].root[30:0], 1'b1};
            end else begin
                n_st[k].rem  = rr;
                n_st[k].root = {r_st[k-1].root[30:0], 1'b0};
            end
            if (r_st[k-1].y > 0) begin
                n_st[k].x = r_st[k-1].x + (r_st[k-1].y >>> (k - 1));
                n_st[k].y = r_st[k-1].y - (r_st[k-1].x >>> (k - 1));
                n_st[k].z = r_st[k-1].z + atan_turns(k - 1);
            end else begin
                n_st[k].x = r_st[k-1].x - (r_st[k-1].y >>> (k - 1));
                n_st[k].y = r_st[k-1].y + (r_st[k-1].x >>> (k - 1));
                n_st[k].z = r_st[k-1].z - atan_turns(k - 1);
            end
        end
    end

    assign o_front.vld  = r_vld[CORDIC_STEPS];
    assign o_front.bin  = r_st[CORDIC_STEPS].bin;
    assign o_front.mag  = r_st[CORDIC_STEPS].root;
    assign o_front.z    = r_st[CORDIC_STEPS].z;
    assign o_front.zero = r_st[CORDIC_STEPS].zero;

endmodule

/* hdl/pvaf_back.sv */
// ----------------------------------------------------------------------------
// pvaf_back
// phase store, phase difference, frequency scaling and saturation
// ----------------------------------------------------------------------------
module pvaf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pvaf_pkg::t_cfg_wr    i_cfg,
    input  pvaf_pkg::t_front_out i_front,
    output logic                 o_clearing,
    output logic                 o_res_vld,
    output pvaf_pkg::t_result    o_res
);
    import pvaf_pkg::*;

    localparam int PW   = PHASE_BITS + 33;
    localparam int HALF = (1 << (32 - PHASE_BITS)) >> 1;

    logic [31:0] r_hop;
    logic [31:0] r_spacing;
    logic [31:0] r_min_mag;

    logic [PHASE_BITS-1:0] mem [0:NUM_BINS-1];

    logic             r_clr;
    logic [CLR_W-1:0] r_clr_addr;

    logic                  r_b0_vld;
    logic [BIN_W-1:0]      r_b0_bin;
    logic [31:0]           r_b0_mag;
    logic [PHASE_BITS-1:0] r_b0_ph;
    logic                  r_b0_upd;
    logic [PHASE_BITS-1:0] r_rd;

    logic                  r_fw_vld;
    logic [CLR_W-1:0]      r_fw_addr;
    logic [PHASE_BITS-1:0] r_fw_data;

    logic                         r_b1_vld;
    logic [BIN_W-1:0]             r_b1_bin;
    logic [31:0]                  r_b1_mag;
    logic signed [PHASE_BITS-1:0] r_b1_d;

    logic               r_b2_vld;
    logic [BIN_W-1:0]   r_b2_bin;
    logic [31:0]        r_b2_mag;
    logic signed [PW-1:0] r_b2_dp;
    logic [41:0]        r_b2_bp;

    logic               r_b3_vld;
    t_result            r_b3;

    logic [31:0]           n_zr;
    logic [PHASE_BITS-1:0] n_ph;
    logic                  n_upd;
    logic [PHASE_BITS-1:0] n_prev;
    logic                  n_we;
    logic [CLR_W-1:0]      n_waddr;
    logic [PHASE_BITS-1:0] n_wdata;
    logic signed [PW-1:0]  n_rnd;
    logic signed [43:0]    n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop     <= 32'd0;
            r_spacing <= 32'd0;
            r_min_mag <= 32'd1;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_HOP_RATE:    r_hop     <= i_cfg.data;
                CFG_BIN_SPACING: r_spacing <= i_cfg.data;
                CFG_MIN_MAG:     r_min_mag <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // rounding of the cordic angle and the update decision
    always_comb begin
        n_zr  = i_front.z + 32'(HALF);
        n_ph  = i_front.zero ? '0 : n_zr[31 -: PHASE_BITS];
        n_upd = (i_front.mag >= r_min_mag) && (i_front.bin < BIN_W'(NUM_BINS));
    end

    always_comb begin
        if (r_fw_vld && (r_fw_addr == r_b0_bin)) begin
            n_prev = r_fw_data;
        end else begin
            n_prev = r_rd;
        end
        n_we    = r_clr || (r_b0_vld && r_b0_upd);
        n_waddr = r_clr ? r_clr_addr : r_b0_bin;
        n_wdata = r_clr ? '0 : r_b0_ph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_fw_vld   <= 1'b0;
            r_b0_vld   <= 1'b0;
            r_b1_vld   <= 1'b0;
            r_b2_vld   <= 1'b0;
            r_b3_vld   <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_W'(NUM_BINS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_fw_vld <= n_we;
            r_b0_vld <= i_front.vld;
            r_b1_vld <= r_b0_vld;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
        end
    end

    // phase store, read registered, write-after-read forwarded
    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_front.bin];
        if (n_we) begin
            mem[n_waddr] <= n_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= n_waddr;
        r_fw_data <= n_wdata;
        r_b0_bin  <= i_front.bin;
        r_b0_mag  <= i_front.mag;
        r_b0_ph   <= n_ph;
        r_b0_upd  <= n_upd;
        r_b1_bin  <= r_b0_bin;
        r_b1_mag  <= r_b0_mag;
        r_b1_d    <= r_b0_upd ? $signed(r_b0_ph - n_prev) : '0;
        r_b2_bin  <= r_b1_bin;
        r_b2_mag  <= r_b1_mag;
        r_b2_dp   <= PW'(r_b1_d * $signed({1'b0, r_hop}));
        r_b2_bp   <= 42'(r_b1_bin * r_spacing);
        r_b3.bin  <= r_b2_bin;
        r_b3.mag  <= r_b2_mag;
        if (n_sum > 44'sh0007FFFFFFF) begin
            r_b3.freq <= 32'sh7FFFFFFF;
        end else if (n_sum < -44'sh00080000000) begin
            r_b3.freq <= 32'sh80000000;
        end else begin
            r_b3.freq <= n_sum[31:0];
        end
    end

    always_comb begin
        n_rnd = r_b2_dp + PW'(1 << (PHASE_BITS - 1));
        n_sum = 44'(n_rnd >>> PHASE_BITS) + $signed({2'b00, r_b2_bp});
    end

    assign o_clearing = r_clr;
    assign o_res_vld  = r_b3_vld;
    assign o_res      = r_b3;

endmodule

/* hdl/pvaf_fifo.sv */
// ----------------------------------------------------------------------------
// pvaf_fifo
// result queue with a registered head for show-ahead output
// ----------------------------------------------------------------------------
module pvaf_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  pvaf_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_vld,
    output pvaf_pkg::t_result o_data
);
    import pvaf_pkg::*;

    t_result         mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_cnt;
    logic            r_ov;
    t_result         r_out;
    logic            n_load;

    assign n_load = (r_cnt != '0) && (!r_ov || i_pop);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[r_wr_ptr] <= i_data;
        end
        if (n_load) begin
            r_out <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (n_load) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_wr) - (Q_AW+1)'(n_load);
            if (n_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_vld  = r_ov;
    assign o_data = r_out;

endmodule

/* hdl/phase_vocoder_bin_amp_freq_unit.sv */
// ----------------------------------------------------------------------------
// phase_vocoder_bin_amp_freq_unit
// magnitude and instantaneous frequency of one fft bin per transaction
// throughput: one transaction per cycle while full is low, set by the fully pipelined root/cordic
// full rises when 64 transactions are outstanding and not yet popped
// reset: synchronous; a pass over all 513 bins clears the phase store, full held high
// ----------------------------------------------------------------------------
module phase_vocoder_bin_amp_freq_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [9:0]         i_bin_index,
    input  logic signed [31:0] i_real_part,
    input  logic signed [31:0] i_imag_part,
    output logic               empty,
    input  logic               pop,
    output logic [9:0]         o_bin_number,
    output logic [31:0]        o_magnitude,
    output logic signed [31:0] o_frequency,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import pvaf_pkg::*;

    logic       accept;
    logic       take;
    logic       clearing;
    logic       res_vld;
    logic       q_vld;
    t_cfg_wr    cfg;
    t_front_out front;
    t_result    res;
    t_result    q_data;
    logic [OUT_W-1:0] r_outst;

    assign accept    = push && !full;
    assign take      = pop && !empty;
    assign full      = clearing || (r_outst == OUT_W'(OUT_LIMIT));
    assign empty     = !q_vld;
    assign cfg.we    = i_cfg_we;
    assign cfg.idx   = t_cfg_idx'(i_cfg_idx);
    assign cfg.data  = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + OUT_W'(accept) - OUT_W'(take);
        end
    end

    pvaf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_bin_index (i_bin_index),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .o_front     (front)
    );

    pvaf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_front    (front),
        .o_clearing (clearing),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    pvaf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_vld),
        .i_data  (res),
        .i_pop   (take),
        .o_vld   (q_vld),
        .o_data  (q_data)
    );

    assign o_bin_number = q_data.bin;
    assign o_magnitude  = q_data.mag;
    assign o_frequency  = q_data.freq;

`ifndef SYNTHESIS
    a_outst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= OUT_W'(OUT_LIMIT))
        else $error("outstanding count above limit");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (r_outst != '0))
        else $error("result popped with nothing outstanding");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !accept && !res_vld)
        else $error("transaction during phase store clear");
`endif

endmodule

/* sim/phase_vocoder_bin_amp_freq_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_vocoder_bin_amp_freq_unit_tb
// self-checking bench: bins are pushed under random idling, each popped
// magnitude and frequency is compared with a software predictor that keeps
// its own phase store and register copies
// ----------------------------------------------------------------------------
module phase_vocoder_bin_amp_freq_unit_tb;
    import pvaf_pkg::*;

    class bin_scoreboard;
        logic [15:0] phase_mem [NUM_BINS];
        logic [31:0] hop, spacing, thresh;
        t_result     pending [$];
        int          errors;

        function void clear();
            foreach (phase_mem[k]) phase_mem[k] = '0;
            hop = 0;
            spacing = 0;
            thresh = 1;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_HOP_RATE:    hop = v;
                CFG_BIN_SPACING: spacing = v;
                CFG_MIN_MAG:     thresh = v;
                default: ;
            endcase
        endfunction

        static function longint fshift(longint v, int s);
            return (v >= 0) ? (v >>> s) : ~((~v) >>> s);
        endfunction

        static function logic [31:0] root64(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r[31:0];
        endfunction

        static function logic [15:0] angle_of(longint x, longint y);
            logic [31:0] z;
            longint dx, dy;
            logic [31:0] zr;
            z = 0;
            if (x == 0 && y == 0) return 16'd0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h80000000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (y > 0) begin
                    x += dx; y -= dy; z += atan_turns(i);
                end else begin
                    x -= dx; y += dy; z -= atan_turns(i);
                end
            end
            zr = z + 32'h8000;
            return zr[31:16];
        endfunction

        function void note_bin(logic [9:0] bin, logic signed [31:0] re,
                               logic signed [31:0] im);
            longint r, i, d, f;
            logic [63:0] sq;
            logic [31:0] mag;
            logic [15:0] ph, diff;
            t_result exp_r;
            r = re;
            i = im;
            sq = r * r + i * i;
            mag = root64(sq);
            d = 0;
            if (mag >= thresh && bin < NUM_BINS) begin
                ph = angle_of(r, i);
                diff = ph - phase_mem[bin];
                d = $signed(diff);
                phase_mem[bin] = ph;
            end
            f = fshift(d * longint'(hop) + 32768, PHASE_BITS)
                + longint'(bin) * longint'(spacing);
            if (f > 64'sd2147483647) f = 64'sd2147483647;
            if (f < -64'sd2147483648) f = -64'sd2147483648;
            exp_r.bin = bin;
            exp_r.mag = mag;
            exp_r.freq = f[31:0];
            pending.push_back(exp_r);
        endfunction

        function void check_result(logic [9:0] bin, logic [31:0] mag,
                                   logic [31:0] freq);
            t_result e;
            if (pending.size() == 0) begin
                report_err("result with nothing outstanding", 0, 0);
                return;
            end
            e = pending.pop_front();
            if (bin !== e.bin) report_err("bin_number", bin, e.bin);
            if (mag !== e.mag) report_err("magnitude", mag, e.mag);
            if (freq !== e.freq) report_err("frequency", freq, e.freq);
        endfunction

        function void report_err(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               push = 0;
    logic               pop = 0;
    logic [9:0]         i_bin_index = 0;
    logic signed [31:0] i_real_part = 0;
    logic signed [31:0] i_imag_part = 0;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_idx = 0;
    logic [31:0]        i_cfg_data = 0;
    wire                full, empty;
    wire [9:0]          o_bin_number;
    wire [31:0]         o_magnitude;
    wire signed [31:0]  o_frequency;

    bin_scoreboard sb = new();
    int  rx_idle_pct = 12;
    int  tx_idle_pct = 12;
    int  hold_off = 0;

    phase_vocoder_bin_amp_freq_unit DUT (
        .i_clk, .i_rst_n, .push, .full, .i_bin_index, .i_real_part, .i_imag_part,
        .empty, .pop, .o_bin_number, .o_magnitude, .o_frequency,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // receiver side
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_bin_number, o_magnitude, o_frequency);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // called at a rising edge; push stays high after acceptance so that
    // transactions can follow back to back
    task automatic send_bin(logic [9:0] bin, logic [31:0] re, logic [31:0] im);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_bin_index <= bin;
        i_real_part <= re;
        i_imag_part <= im;
        do @(posedge i_clk); while (full);
        sb.note_bin(bin, re, im);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return $urandom_range(2000) - 1000;
            1: return 32'h80000000;
            2: return 32'h7FFFFFFF;
            3: return $urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n, logic [9:0] bin_hi);
        for (int k = 0; k < n; k++)
            send_bin($urandom_range(bin_hi), rand_part(), rand_part());
    endtask

    initial begin
        sb.clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        send_bin(0, 0, 0);
        send_bin(5, 1000, 0);
        send_bin(5, 0, 1000);
        send_bin(5, -1000, 0);
        send_bin(5, 1000, 0);
        send_bin(5, 0, 0);
        send_bin(512, 32'h80000000, 32'h80000000);
        send_bin(1023, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_bin(513, 7, -7);
        drain();
        write_reg(CFG_HOP_RATE, 32'hFFFFFFFF);
        write_reg(CFG_BIN_SPACING, 32'hFFFFFFFF);
        write_reg(CFG_MIN_MAG, 0);
        send_bin(3, 0, 0);
        send_bin(3, -100, 1);
        send_bin(3, -100, -1);
        send_bin(512, 32'h80000000, 0);
        send_bin(0, 0, 32'h80000000);
        send_bin(7, 100, 0);
        send_bin(7, -100, 0);
        send_bin(7, 100, 0);
        send_bin(1023, -1, -1);
        drain();
        // random phases over register settings
        write_reg(CFG_HOP_RATE, 32'd44100 * 4096 / 256);
        write_reg(CFG_BIN_SPACING, 32'd44100 * 4096 / 1024);
        write_reg(CFG_MIN_MAG, 50);
        random_phase(400, 15);
        // no idling, then long receiver hold-off to fill the block
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(150, 1023);
        hold_off = 300;
        random_phase(120, 512);
        drain();
        tx_idle_pct = 12;
        rx_idle_pct = 12;
        write_reg(CFG_HOP_RATE, $urandom);
        write_reg(CFG_BIN_SPACING, $urandom);
        write_reg(CFG_MIN_MAG, 32'hFFFFFFFF);
        random_phase(150, 1023);
        drain();
        write_reg(CFG_HOP_RATE, $urandom);
        write_reg(CFG_BIN_SPACING, $urandom_range(4096));
        write_reg(CFG_MIN_MAG, $urandom_range(1000));
        random_phase(350, 31);
        drain();
        write_reg(CFG_HOP_RATE, 32'hFFFFFFFF);
        write_reg(CFG_BIN_SPACING, 0);
        write_reg(CFG_MIN_MAG, 1);
        random_phase(360, 1023);
        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* files.f */
hdl/pvaf_pkg.sv
hdl/pvaf_front.sv
hdl/pvaf_back.sv
hdl/pvaf_fifo.sv
hdl/phase_vocoder_bin_amp_freq_unit.sv
sim/phase_vocoder_bin_amp_freq_unit_tb.sv
